// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/sgsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Gear shift controller package
// Item types, register indexes and reset values of the gear shift controller.
// ----------------------------------------------------------------------------
package sgsc_pkg;

   localparam int GEAR_W   = 4;
   localparam int WANTED_W = 6;
   localparam int TIME_W   = 32;
   localparam int PULSE_W  = 16;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_GEAR      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_TIME    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL_TIME  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_PERIOD = 2'd3;

   localparam logic [GEAR_W-1:0]  TOP_GEAR_RESET      = 4'd5;
   localparam logic [PULSE_W-1:0] SHIFT_TIME_RESET    = 16'd50;
   localparam logic [PULSE_W-1:0] NEUTRAL_TIME_RESET  = 16'd30;
   localparam logic [PULSE_W-1:0] STATUS_PERIOD_RESET = 16'd100;

   typedef struct packed {
      logic              up_request;
      logic              down_request;
      logic              clutch_in;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic              up_actuate;
      logic              down_actuate;
      logic [GEAR_W-1:0] gear_now;
      logic              send_status;
      logic              status_shifting;
      logic              led_level;
   } rsp_type;

endpackage

// ===== src/sequential_gear_shift_controller.sv =====
// ----------------------------------------------------------------------------
// Sequential gear shift controller
// Paddle shift sequencer with actuator pulse timing and periodic status.
// ----------------------------------------------------------------------------
// Each req item is one control-loop pass and produces exactly one rsp item.
// An item is captured in an input register and processed, once the result
// register is empty or draining, by one pass of combinational logic, which
// updates the gear state and loads the result register; one item per clock is
// sustained while rsp_ready is high, limited only by the state update loop.
// rsp_valid comes from the result register, behind the input register. The
// input register refills while a result waits, so the block stalls only when
// both registers are full and rsp_ready is low. Register writes are taken at
// any time but must only be issued while the block is idle.
module sequential_gear_shift_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sgsc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sgsc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sgsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgsc_pkg::PULSE_W-1:0]         csr_data
);

   // Configuration registers.
   logic [sgsc_pkg::GEAR_W-1:0]  top_gear_ff;
   logic [sgsc_pkg::PULSE_W-1:0] shift_time_ff;
   logic [sgsc_pkg::PULSE_W-1:0] neutral_time_ff;
   logic [sgsc_pkg::PULSE_W-1:0] status_period_ff;

   // Controller state.
   logic [sgsc_pkg::GEAR_W-1:0]          engaged_ff, engaged_in;
   logic signed [sgsc_pkg::WANTED_W-1:0] wanted_ff, wanted_in;
   logic                                 up_active_ff, up_active_in;
   logic                                 down_active_ff, down_active_in;
   logic [sgsc_pkg::TIME_W-1:0]          deadline_ff, deadline_in;
   logic [sgsc_pkg::TIME_W-1:0]          next_status_ff, next_status_in;
   logic                                 led_ff, led_in;

   // Input and result registers.
   logic               in_valid_ff;
   sgsc_pkg::req_type  in_data_ff;
   logic               rsp_valid_ff;
   sgsc_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      logic [sgsc_pkg::GEAR_W-1:0]          eng;
      logic signed [sgsc_pkg::WANTED_W-1:0] eng_ext;
      logic signed [sgsc_pkg::WANTED_W-1:0] top_ext;
      logic signed [sgsc_pkg::WANTED_W-1:0] w;
      logic                                 up_n;
      logic                                 dn_n;
      logic                                 drive;
      logic [sgsc_pkg::PULSE_W-1:0]         pulse_len;
      logic                                 send;
      logic                                 shifting;
      logic [sgsc_pkg::TIME_W-1:0]          now;

      now       = in_data_ff.now_ms;
      eng       = engaged_ff;
      up_n      = up_active_ff;
      dn_n      = down_active_ff;
      drive     = 1'b0;
      pulse_len = shift_time_ff;
      send      = 1'b0;
      shifting  = 1'b0;
      led_in    = led_ff;
      next_status_in = next_status_ff;

      // A shift whose deadline has come commits the target gear.
      if ((up_active_ff || down_active_ff) && now >= deadline_ff) begin
         eng  = wanted_ff[sgsc_pkg::GEAR_W-1:0];
         up_n = 1'b0;
         dn_n = 1'b0;
      end
      eng_ext = $signed({2'b00, eng});
      top_ext = $signed({2'b00, top_gear_ff});
      w       = wanted_ff;

      // Up request. Neutral to first uses the down actuator and needs the clutch.
      if (in_data_ff.up_request) begin
         if (w == eng_ext) begin
            w = w + 6'sd1;
         end
         if (w > top_ext) begin
            w = top_ext;
         end else if (w > 6'sd1) begin
            up_n      = 1'b1;
            drive     = 1'b1;
            pulse_len = shift_time_ff;
         end else if (w == 6'sd1 && in_data_ff.clutch_in) begin
            dn_n      = 1'b1;
            drive     = 1'b1;
            pulse_len = shift_time_ff;
         end else begin
            w = eng_ext;
         end
      end

      // Down request. First to neutral uses the up actuator and the neutral pulse.
      if (in_data_ff.down_request) begin
         if (w == eng_ext) begin
            w = w - 6'sd1;
         end
         if (w < 6'sd0) begin
            w   = 6'sd0;
            eng = '0;
         end else if (w < 6'sd1) begin
            up_n      = 1'b1;
            drive     = 1'b1;
            pulse_len = neutral_time_ff;
         end else begin
            dn_n      = 1'b1;
            drive     = 1'b1;
            pulse_len = shift_time_ff;
         end
      end

      if (next_status_ff < now) begin
         send           = 1'b1;
         led_in         = !led_ff;
         shifting       = up_n || dn_n;
         next_status_in = now + {{(sgsc_pkg::TIME_W-sgsc_pkg::PULSE_W){1'b0}},
                                 status_period_ff};
      end

      deadline_in = drive ? now + {{(sgsc_pkg::TIME_W-sgsc_pkg::PULSE_W){1'b0}}, pulse_len}
                          : deadline_ff;
      engaged_in     = eng;
      wanted_in      = w;
      up_active_in   = up_n;
      down_active_in = dn_n;

      rsp_data_in.up_actuate      = up_n;
      rsp_data_in.down_actuate    = dn_n;
      rsp_data_in.gear_now        = eng;
      rsp_data_in.send_status     = send;
      rsp_data_in.status_shifting = shifting;
      rsp_data_in.led_level       = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_gear_ff      <= sgsc_pkg::TOP_GEAR_RESET;
         shift_time_ff    <= sgsc_pkg::SHIFT_TIME_RESET;
         neutral_time_ff  <= sgsc_pkg::NEUTRAL_TIME_RESET;
         status_period_ff <= sgsc_pkg::STATUS_PERIOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sgsc_pkg::CSR_TOP_GEAR:      top_gear_ff <= csr_data[sgsc_pkg::GEAR_W-1:0];
            sgsc_pkg::CSR_SHIFT_TIME:    shift_time_ff <= csr_data;
            sgsc_pkg::CSR_NEUTRAL_TIME:  neutral_time_ff <= csr_data;
            sgsc_pkg::CSR_STATUS_PERIOD: status_period_ff <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         engaged_ff     <= '0;
         wanted_ff      <= '0;
         up_active_ff   <= 1'b0;
         down_active_ff <= 1'b0;
         deadline_ff    <= '0;
         next_status_ff <= '0;
         led_ff         <= 1'b0;
      end else if (advance) begin
         engaged_ff     <= engaged_in;
         wanted_ff      <= wanted_in;
         up_active_ff   <= up_active_in;
         down_active_ff <= down_active_in;
         deadline_ff    <= deadline_in;
         next_status_ff <= next_status_in;
         led_ff         <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== src/sgsc_checker.sv =====
// ----------------------------------------------------------------------------
// Gear shift controller checker
// Port-level checks of the gear shift controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgsc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input sgsc_pkg::rsp_type              rsp_data
);

   // No result item survives a reset.
   `ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "rsp_valid after reset")

   // The shifting flag is only reported in a status message.
   `ASSERT_CLK(a_shifting_needs_send, rsp_valid && !rsp_data.send_status |-> !rsp_data.status_shifting, "status_shifting without send_status")

   // A draining output never holds back the input side.
   `ASSERT_CLK(a_no_stall_when_drained, rsp_ready |-> req_ready, "req_ready low while rsp_ready high")

   // A pending result item is not withdrawn.
   `ASSERT_CLK(a_rsp_valid_held, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped while stalled")

endmodule

bind sequential_gear_shift_controller sgsc_checker u_sgsc_checker (.*);
